// ===== design/bmr_pkg.sv =====
// Shared types, opcodes and field widths of the bit matrix row engine.
`default_nettype none
package bmr_pkg;

   localparam int OP_W     = 3;
   localparam int ROW_W    = 6;
   localparam int POS_W    = 8;
   localparam int SEL_W    = 6;
   localparam int COUNT_W  = 9;
   localparam int CFG_W    = 3;
   localparam int WORD_W   = 64;
   localparam int ONES_W   = 7;

   // Opcodes
   localparam logic [OP_W-1:0] OP_SET_BIT   = 3'd0;
   localparam logic [OP_W-1:0] OP_CLEAR_BIT = 3'd1;
   localparam logic [OP_W-1:0] OP_TEST_BIT  = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_ROW = 3'd3;
   localparam logic [OP_W-1:0] OP_POPCOUNT  = 3'd4;
   localparam logic [OP_W-1:0] OP_OR_ROWS   = 3'd5;
   localparam logic [OP_W-1:0] OP_AND_ROWS  = 3'd6;

   localparam logic [CFG_W-1:0] WORDS_IN_USE_RESET = 3'd4;

   typedef logic [WORD_W-1:0] word_type;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [SEL_W-1:0] bit_sel;
   } unit_ctrl_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctrl_type;

endpackage
`default_nettype wire

// ===== design/bmr_if.sv =====
// Request and response channel interfaces of the bit matrix row engine.
`default_nettype none
interface bmr_req_if;
   logic                        valid;
   logic                        ready;
   logic [bmr_pkg::OP_W-1:0]    opcode;
   logic [bmr_pkg::ROW_W-1:0]   target_row;
   logic [bmr_pkg::ROW_W-1:0]   source_row;
   logic [bmr_pkg::POS_W-1:0]   bit_position;

   modport source (output valid, output opcode, output target_row, output source_row,
                   output bit_position, input ready);
   modport sink   (input valid, input opcode, input target_row, input source_row,
                   input bit_position, output ready);
endinterface

interface bmr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        bit_value;
   logic [bmr_pkg::COUNT_W-1:0] set_count;

   modport source (output valid, output bit_value, output set_count, input ready);
   modport sink   (input valid, input bit_value, input set_count, output ready);
endinterface
`default_nettype wire

// ===== design/bmr_word_unit.sv =====
// Shared word unit: bit set/clear, row OR/AND, row clear, bit test and word popcount.
`default_nettype none
module bmr_word_unit (
   input  wire bmr_pkg::unit_ctrl_type       ctrl,
   input  wire bmr_pkg::word_type            target_word,
   input  wire bmr_pkg::word_type            source_word,
   output bmr_pkg::word_type                 new_word,
   output logic                              bit_out,
   output logic [bmr_pkg::ONES_W-1:0]        ones
);

   bmr_pkg::word_type mask;

   assign mask    = bmr_pkg::word_type'(1) << ctrl.bit_sel;
   assign bit_out = target_word[ctrl.bit_sel];
   assign ones    = bmr_pkg::ONES_W'($countones(target_word));

   always_comb begin
      unique case (ctrl.opcode)
         bmr_pkg::OP_SET_BIT:   new_word = target_word | mask;
         bmr_pkg::OP_CLEAR_BIT: new_word = target_word & ~mask;
         bmr_pkg::OP_OR_ROWS:   new_word = target_word | source_word;
         bmr_pkg::OP_AND_ROWS:  new_word = target_word & source_word;
         bmr_pkg::OP_CLEAR_ROW: new_word = '0;
         default:               new_word = target_word;
      endcase
   end

endmodule
`default_nettype wire

// ===== design/bmr_store.sv =====
// Row word memory: one write port, one read port, registered read data.
`default_nettype none
module bmr_store #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  wire                          clock,
   input  wire bmr_pkg::mem_ctrl_type   ctrl,
   input  wire [ADDR_W-1:0]             wr_addr,
   input  wire bmr_pkg::word_type       wr_data,
   input  wire [ADDR_W-1:0]             rd_addr,
   output bmr_pkg::word_type            rd_data
);

   bmr_pkg::word_type mem [DEPTH];
   bmr_pkg::word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/bit_matrix_row_engine_top.sv =====
// Top level of the bit matrix row engine: sequencer, config register, output register.
// Items run one word at a time over nw = active words per row: set/clear/test bit touch one word,
// clear row, popcount and OR/AND rows cover nw words; out-of-range items are dropped, or
// answered with a zero result for test bit and popcount.
// One item at a time: ready is high only in idle; a result that waits on a
// full output register stalls the block in its result state until rsp_ch takes the item.
// Reset (synchronous, active high) starts a clearing pass over min(ROW_COUNT,64)*
// MAX_WORDS_PER_ROW words, one word per cycle; no item is taken during it.
`default_nettype none
module bit_matrix_row_engine_top #(
   parameter int ROW_COUNT         = 64,
   parameter int MAX_WORDS_PER_ROW = 4
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            csr_write_enable,
   input  wire [bmr_pkg::CFG_W-1:0]       csr_write_data,
   bmr_req_if.sink                        req_ch,
   bmr_rsp_if.source                      rsp_ch
);

   // Only rows reachable through the 6-bit row fields are stored.
   localparam int ROWS_USED = (ROW_COUNT < 64) ? ROW_COUNT : 64;
   localparam int DEPTH     = ROWS_USED * MAX_WORDS_PER_ROW;
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WIDX_W    = (MAX_WORDS_PER_ROW > 1) ? $clog2(MAX_WORDS_PER_ROW) : 1;
   // words_in_use is 3 bits, so at most 7 words ever take part; 7*64 fits the count.
   localparam int NW_MAX    = (MAX_WORDS_PER_ROW < 7) ? MAX_WORDS_PER_ROW : 7;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ_T = 3'd2;
   localparam logic [2:0] ST_READ_S = 3'd3;
   localparam logic [2:0] ST_EXEC   = 3'd4;
   localparam logic [2:0] ST_ZERO   = 3'd5;
   localparam logic [2:0] ST_PUT    = 3'd6;

   logic [2:0]                    state_ff, state_in;
   logic [ADDR_W-1:0]             clr_ff, clr_in;
   logic [bmr_pkg::CFG_W-1:0]     words_in_use_ff;
   logic [bmr_pkg::OP_W-1:0]      op_ff, op_in;
   logic [bmr_pkg::ROW_W-1:0]     trow_ff, trow_in;
   logic [bmr_pkg::ROW_W-1:0]     srow_ff, srow_in;
   logic [bmr_pkg::SEL_W-1:0]     sel_ff, sel_in;
   logic [WIDX_W-1:0]             w_ff, w_in;
   logic [WIDX_W-1:0]             last_ff, last_in;
   bmr_pkg::word_type             hold_ff, hold_in;
   logic [bmr_pkg::COUNT_W-1:0]   acc_ff, acc_in;
   logic                          res_bit_ff, res_bit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_bit_ff, rsp_bit_in;
   logic [bmr_pkg::COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // Active word count: zero acts as one, anything above the row size is clamped.
   logic [bmr_pkg::CFG_W-1:0]     nw;
   logic                          trow_ok, srow_ok, pos_ok, is_rowop;
   logic [ADDR_W-1:0]             tbase, sbase;

   bmr_pkg::mem_ctrl_type         mem_ctrl;
   logic [ADDR_W-1:0]             mem_wr_addr, mem_rd_addr;
   bmr_pkg::word_type             mem_wr_data, mem_rd_data;

   bmr_pkg::unit_ctrl_type        unit_ctrl;
   bmr_pkg::word_type             unit_target, unit_new;
   logic                          unit_bit;
   logic [bmr_pkg::ONES_W-1:0]    unit_ones;

   always_comb begin
      priority if (words_in_use_ff == '0) begin
         nw = bmr_pkg::CFG_W'(1);
      end else if (int'(words_in_use_ff) > NW_MAX) begin
         nw = bmr_pkg::CFG_W'(NW_MAX);
      end else begin
         nw = words_in_use_ff;
      end
   end

   assign trow_ok  = int'(req_ch.target_row) < ROW_COUNT;
   assign srow_ok  = int'(req_ch.source_row) < ROW_COUNT;
   assign pos_ok   = {1'b0, req_ch.bit_position[7:6]} < nw;
   assign is_rowop = (op_ff == bmr_pkg::OP_OR_ROWS) || (op_ff == bmr_pkg::OP_AND_ROWS);

   assign tbase = ADDR_W'(trow_ff) * ADDR_W'(MAX_WORDS_PER_ROW);
   assign sbase = ADDR_W'(srow_ff) * ADDR_W'(MAX_WORDS_PER_ROW);

   assign req_ch.ready = (state_ff == ST_IDLE);

   // Target word comes straight from memory, except for OR/AND where it was parked.
   assign unit_ctrl.opcode  = op_ff;
   assign unit_ctrl.bit_sel = sel_ff;
   assign unit_target       = is_rowop ? hold_ff : mem_rd_data;

   bmr_word_unit u_unit (
      .ctrl        (unit_ctrl),
      .target_word (unit_target),
      .source_word (mem_rd_data),
      .new_word    (unit_new),
      .bit_out     (unit_bit),
      .ones        (unit_ones)
   );

   bmr_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .ctrl    (mem_ctrl),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      op_in        = op_ff;
      trow_in      = trow_ff;
      srow_in      = srow_ff;
      sel_in       = sel_ff;
      w_in         = w_ff;
      last_in      = last_ff;
      hold_in      = hold_ff;
      acc_in       = acc_ff;
      res_bit_in   = res_bit_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_count_in = rsp_count_ff;
      mem_ctrl     = '0;
      mem_wr_addr  = tbase + ADDR_W'(w_ff);
      mem_wr_data  = unit_new;
      mem_rd_addr  = tbase + ADDR_W'(w_ff);

      // taken result leaves the output register
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_ctrl.wr_en = 1'b1;
            mem_wr_addr    = clr_ff;
            mem_wr_data    = '0;
            clr_in         = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_ch.valid) begin
               op_in      = req_ch.opcode;
               trow_in    = req_ch.target_row;
               srow_in    = req_ch.source_row;
               sel_in     = req_ch.bit_position[5:0];
               last_in    = WIDX_W'(nw - bmr_pkg::CFG_W'(1));
               acc_in     = '0;
               res_bit_in = 1'b0;
               w_in       = '0;
               unique case (req_ch.opcode)
                  bmr_pkg::OP_SET_BIT, bmr_pkg::OP_CLEAR_BIT: begin
                     w_in     = WIDX_W'(req_ch.bit_position[7:6]);
                     state_in = (trow_ok && pos_ok) ? ST_READ_T : ST_IDLE;
                  end
                  bmr_pkg::OP_TEST_BIT: begin
                     w_in     = WIDX_W'(req_ch.bit_position[7:6]);
                     state_in = (trow_ok && pos_ok) ? ST_READ_T : ST_PUT;
                  end
                  bmr_pkg::OP_CLEAR_ROW: begin
                     state_in = trow_ok ? ST_ZERO : ST_IDLE;
                  end
                  bmr_pkg::OP_POPCOUNT: begin
                     state_in = trow_ok ? ST_READ_T : ST_PUT;
                  end
                  bmr_pkg::OP_OR_ROWS, bmr_pkg::OP_AND_ROWS: begin
                     state_in = (trow_ok && srow_ok &&
                                 (req_ch.target_row != req_ch.source_row)) ?
                                ST_READ_T : ST_IDLE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_READ_T: begin
            mem_ctrl.rd_en = 1'b1;
            state_in       = is_rowop ? ST_READ_S : ST_EXEC;
         end
         ST_READ_S: begin
            hold_in        = mem_rd_data;
            mem_ctrl.rd_en = 1'b1;
            mem_rd_addr    = sbase + ADDR_W'(w_ff);
            state_in       = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (op_ff)
               bmr_pkg::OP_TEST_BIT: begin
                  res_bit_in = unit_bit;
                  state_in   = ST_PUT;
               end
               bmr_pkg::OP_POPCOUNT: begin
                  acc_in = acc_ff + bmr_pkg::COUNT_W'(unit_ones);
                  w_in   = w_ff + WIDX_W'(1);
                  state_in = (w_ff == last_ff) ? ST_PUT : ST_READ_T;
               end
               bmr_pkg::OP_OR_ROWS, bmr_pkg::OP_AND_ROWS: begin
                  mem_ctrl.wr_en = 1'b1;
                  w_in     = w_ff + WIDX_W'(1);
                  state_in = (w_ff == last_ff) ? ST_IDLE : ST_READ_T;
               end
               default: begin
                  // set or clear one bit
                  mem_ctrl.wr_en = 1'b1;
                  state_in       = ST_IDLE;
               end
            endcase
         end
         ST_ZERO: begin
            mem_ctrl.wr_en = 1'b1;
            w_in     = w_ff + WIDX_W'(1);
            state_in = (w_ff == last_ff) ? ST_IDLE : ST_ZERO;
         end
         ST_PUT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_bit_in   = res_bit_ff;
               rsp_count_in = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clr_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         words_in_use_ff <= bmr_pkg::WORDS_IN_USE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            words_in_use_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      trow_ff      <= trow_in;
      srow_ff      <= srow_in;
      sel_ff       <= sel_in;
      w_ff         <= w_in;
      last_ff      <= last_in;
      hold_ff      <= hold_in;
      acc_ff       <= acc_in;
      res_bit_ff   <= res_bit_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.bit_value = rsp_bit_ff;
   assign rsp_ch.set_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !req_ch.ready)
      else $error("item offered ready during clearing pass");

   a_word_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ_T || state_ff == ST_READ_S || state_ff == ST_EXEC ||
       state_ff == ST_ZERO) |-> (w_ff <= last_ff))
      else $error("word counter beyond active words");

   a_result_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_bit_ff || rsp_count_ff == '0))
      else $error("result carries both a bit and a count");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_ctrl.wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_EXEC ||
                          state_ff == ST_ZERO))
      else $error("memory write outside a write state");
`endif

endmodule
`default_nettype wire

// ===== tb/bit_matrix_row_engine_top_tb.sv =====
// Testbench for the bit matrix row engine: directed and random row commands vs. a predictor.
module bit_matrix_row_engine_top_tb;

   // Block sizes used by the predictor (match the DUT defaults)
   localparam int ROW_COUNT         = 64;
   localparam int MAX_WORDS_PER_ROW = 4;

   // Opcode 7 has no function; the block must drop it without a result
   localparam logic [bmr_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

   // Longest item is an OR/AND row pass at four words
   localparam int SETTLE_CYCLES = 16;
   // Receiver hold-off long enough to back the block up into its input
   localparam int HOLD_CYCLES   = 300;
   // Cycles without any accepted item before the run is declared hung;
   // covers the clearing pass, the hold-off and the longest gaps
   localparam int IDLE_LIMIT    = 5000;
   localparam int MAX_REPORTS   = 10;

   typedef struct packed {
      logic [bmr_pkg::OP_W-1:0]  opcode;
      logic [bmr_pkg::ROW_W-1:0] target_row;
      logic [bmr_pkg::ROW_W-1:0] source_row;
      logic [bmr_pkg::POS_W-1:0] bit_position;
   } row_cmd_type;

   typedef struct packed {
      logic                        bit_value;
      logic [bmr_pkg::COUNT_W-1:0] set_count;
   } row_result_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_write_enable;
   logic [bmr_pkg::CFG_W-1:0] csr_write_data;

   bmr_req_if req_ch ();
   bmr_rsp_if rsp_ch ();

   bit_matrix_row_engine_top #(
      .ROW_COUNT        (ROW_COUNT),
      .MAX_WORDS_PER_ROW(MAX_WORDS_PER_ROW)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: shadow copy of the bit store and the words register
   logic [bmr_pkg::WORD_W-1:0] row_words [ROW_COUNT][MAX_WORDS_PER_ROW];
   logic [bmr_pkg::CFG_W-1:0]  words_in_use_shadow;

   // Results predicted but not yet seen on the response channel
   row_result_type pending_results[$];

   int unsigned mismatch_count;
   bit          gaps_enabled;      // random idling on both channels
   int unsigned rsp_hold_cycles;   // requested receiver hold-off
   int unsigned idle_cycles;

   // Words that operations cover: 0 acts as 1, values above the row size clamp
   function automatic int active_words();
      if (words_in_use_shadow == '0)
         return 1;
      if (words_in_use_shadow > MAX_WORDS_PER_ROW)
         return MAX_WORDS_PER_ROW;
      return int'(words_in_use_shadow);
   endfunction

   // Applies one command to the shadow store; returns 1 when it yields a result.
   function automatic bit apply_row_cmd(input row_cmd_type cmd, output row_result_type res);
      int                         nw;
      int                         word_sel;
      int                         total;
      bit                         pos_ok;
      bit                         trow_ok;
      bit                         srow_ok;
      bit                         rows_differ;
      logic [bmr_pkg::WORD_W-1:0] mask;
      nw          = active_words();
      word_sel    = int'(cmd.bit_position >> 6);
      mask        = 64'd1 << cmd.bit_position[5:0];
      pos_ok      = word_sel < nw;
      trow_ok     = int'(cmd.target_row) < ROW_COUNT;
      srow_ok     = int'(cmd.source_row) < ROW_COUNT;
      rows_differ = cmd.target_row != cmd.source_row;
      res         = '0;
      case (cmd.opcode)
         bmr_pkg::OP_SET_BIT: begin
            if (trow_ok && pos_ok)
               row_words[cmd.target_row][word_sel] |= mask;
            return 1'b0;
         end
         bmr_pkg::OP_CLEAR_BIT: begin
            if (trow_ok && pos_ok)
               row_words[cmd.target_row][word_sel] &= ~mask;
            return 1'b0;
         end
         bmr_pkg::OP_TEST_BIT: begin
            if (trow_ok && pos_ok)
               res.bit_value = |(row_words[cmd.target_row][word_sel] & mask);
            return 1'b1;
         end
         bmr_pkg::OP_CLEAR_ROW: begin
            if (trow_ok)
               for (int w = 0; w < nw; w++)
                  row_words[cmd.target_row][w] = '0;
            return 1'b0;
         end
         bmr_pkg::OP_POPCOUNT: begin
            total = 0;
            if (trow_ok)
               for (int w = 0; w < nw; w++)
                  total += $countones(row_words[cmd.target_row][w]);
            res.set_count = (total > 511) ? 9'd511 : bmr_pkg::COUNT_W'(total);
            return 1'b1;
         end
         bmr_pkg::OP_OR_ROWS: begin
            if (trow_ok && srow_ok && rows_differ)
               for (int w = 0; w < nw; w++)
                  row_words[cmd.target_row][w] |= row_words[cmd.source_row][w];
            return 1'b0;
         end
         bmr_pkg::OP_AND_ROWS: begin
            if (trow_ok && srow_ok && rows_differ)
               for (int w = 0; w < nw; w++)
                  row_words[cmd.target_row][w] &= row_words[cmd.source_row][w];
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int unsigned draw_gap();
      int unsigned pick;
      pick = $urandom_range(99);
      if (!gaps_enabled || pick < 65)
         return 0;
      if (pick < 95)
         return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Offers one item, waits for the handshake, predicts, then maybe idles.
   // valid stays high when no gap follows, so back-to-back items need one NBA per step.
   task automatic send_row_cmd(input logic [bmr_pkg::OP_W-1:0]  opcode,
                               input logic [bmr_pkg::ROW_W-1:0] trow,
                               input logic [bmr_pkg::ROW_W-1:0] srow,
                               input logic [bmr_pkg::POS_W-1:0] pos);
      row_cmd_type    cmd;
      row_result_type res;
      int unsigned    gap;
      cmd = '{opcode: opcode, target_row: trow, source_row: srow, bit_position: pos};
      req_ch.valid        <= 1'b1;
      req_ch.opcode       <= opcode;
      req_ch.target_row   <= trow;
      req_ch.source_row   <= srow;
      req_ch.bit_position <= pos;
      do
         @(posedge clock);
      while (!req_ch.ready);
      if (apply_row_cmd(cmd, res))
         pending_results.push_back(res);
      gap = draw_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Random command: rows bunched into a few so operations interact,
   // bit positions mostly inside the covered words
   task automatic send_random_cmd();
      int unsigned                pick;
      logic [bmr_pkg::OP_W-1:0]   opcode;
      logic [bmr_pkg::ROW_W-1:0]  trow;
      logic [bmr_pkg::ROW_W-1:0]  srow;
      logic [bmr_pkg::POS_W-1:0]  pos;
      pick = $urandom_range(99);
      if (pick < 28)      opcode = bmr_pkg::OP_SET_BIT;
      else if (pick < 38) opcode = bmr_pkg::OP_CLEAR_BIT;
      else if (pick < 58) opcode = bmr_pkg::OP_TEST_BIT;
      else if (pick < 61) opcode = bmr_pkg::OP_CLEAR_ROW;
      else if (pick < 75) opcode = bmr_pkg::OP_POPCOUNT;
      else if (pick < 87) opcode = bmr_pkg::OP_OR_ROWS;
      else if (pick < 98) opcode = bmr_pkg::OP_AND_ROWS;
      else                opcode = OP_UNUSED;
      trow = ($urandom_range(4) == 0) ? bmr_pkg::ROW_W'($urandom) :
                                        bmr_pkg::ROW_W'($urandom_range(7));
      if ($urandom_range(7) == 0)
         srow = trow;
      else
         srow = ($urandom_range(4) == 0) ? bmr_pkg::ROW_W'($urandom) :
                                           bmr_pkg::ROW_W'($urandom_range(7));
      if ($urandom_range(4) == 0)
         pos = bmr_pkg::POS_W'($urandom);
      else
         pos = bmr_pkg::POS_W'($urandom_range(active_words() * 64 - 1));
      send_row_cmd(opcode, trow, srow, pos);
   endtask

   // Stops offering and waits until every predicted result has come back,
   // then lets trailing no-result work finish
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_words_in_use(input logic [bmr_pkg::CFG_W-1:0] value);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable    <= 1'b0;
      words_in_use_shadow  = value;
   endtask

   // Extremes of the fields, every opcode, same-row OR/AND, positions beyond
   // the covered words and words kept outside use
   task automatic test_directed();
      send_row_cmd(bmr_pkg::OP_SET_BIT, 6'd0, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_SET_BIT, 6'd63, 6'd0, 8'd255);
      send_row_cmd(bmr_pkg::OP_SET_BIT, 6'd0, 6'd0, 8'd63);
      send_row_cmd(bmr_pkg::OP_SET_BIT, 6'd0, 6'd0, 8'd64);
      send_row_cmd(bmr_pkg::OP_TEST_BIT, 6'd0, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_TEST_BIT, 6'd63, 6'd63, 8'd255);
      send_row_cmd(bmr_pkg::OP_TEST_BIT, 6'd0, 6'd0, 8'd1);
      send_row_cmd(bmr_pkg::OP_CLEAR_BIT, 6'd0, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_TEST_BIT, 6'd0, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_POPCOUNT, 6'd0, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_POPCOUNT, 6'd63, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_OR_ROWS, 6'd1, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_OR_ROWS, 6'd63, 6'd63, 8'd0);   // same row: no change
      send_row_cmd(bmr_pkg::OP_AND_ROWS, 6'd1, 6'd63, 8'd0);
      send_row_cmd(bmr_pkg::OP_POPCOUNT, 6'd1, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_AND_ROWS, 6'd0, 6'd0, 8'd0);    // same row: no change
      send_row_cmd(OP_UNUSED, 6'd63, 6'd63, 8'd255);           // dropped, no result
      send_row_cmd(bmr_pkg::OP_CLEAR_ROW, 6'd0, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_POPCOUNT, 6'd0, 6'd0, 8'd0);
      // one word in use: upper positions are ignored and upper words kept
      write_words_in_use(3'd1);
      send_row_cmd(bmr_pkg::OP_SET_BIT, 6'd2, 6'd0, 8'd200);
      send_row_cmd(bmr_pkg::OP_TEST_BIT, 6'd2, 6'd0, 8'd200);
      send_row_cmd(bmr_pkg::OP_TEST_BIT, 6'd63, 6'd0, 8'd255);
      send_row_cmd(bmr_pkg::OP_POPCOUNT, 6'd63, 6'd0, 8'd0);
      write_words_in_use(3'd4);
      send_row_cmd(bmr_pkg::OP_POPCOUNT, 6'd63, 6'd0, 8'd0);
      send_row_cmd(bmr_pkg::OP_TEST_BIT, 6'd63, 6'd0, 8'd255);
   endtask

   // Random phases across register settings, out-of-range codes included;
   // every third phase runs with no idling on either side
   task automatic test_words_in_use_sweep();
      logic [bmr_pkg::CFG_W-1:0] settings[9];
      settings = '{3'd1, 3'd4, 3'd2, 3'd0, 3'd3, 3'd7, 3'd5, 3'd6, 3'd4};
      foreach (settings[i]) begin
         write_words_in_use(settings[i]);
         gaps_enabled = (i % 3) != 2;
         repeat (80) send_random_cmd();
      end
      gaps_enabled = 1'b1;
   endtask

   // Receiver holds off for a long stretch while items keep coming, so the
   // output fills and the block stalls its input
   task automatic test_result_backpressure();
      drain_results();
      gaps_enabled    = 1'b0;
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 40; i++) begin
         if (i % 2 == 0)
            send_row_cmd(bmr_pkg::OP_TEST_BIT, bmr_pkg::ROW_W'($urandom_range(7)), 6'd0,
                         bmr_pkg::POS_W'($urandom));
         else
            send_row_cmd(bmr_pkg::OP_POPCOUNT, bmr_pkg::ROW_W'($urandom_range(7)), 6'd0,
                         8'd0);
      end
      gaps_enabled = 1'b1;
   endtask

   // Sender pauses until every result is home, then resumes
   task automatic test_drain_pause();
      repeat (20) send_random_cmd();
      drain_results();
      repeat (20) send_random_cmd();
   endtask

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("tb: mismatch at %0t: %s", $time, what);
   endtask

   // Result checker: each accepted result against the oldest prediction
   always @(posedge clock) begin
      row_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result bit_value=%0d set_count=%0d",
                                      rsp_ch.bit_value, rsp_ch.set_count));
         end else begin
            want = pending_results.pop_front();
            if (rsp_ch.bit_value !== want.bit_value)
               report_mismatch($sformatf("bit_value expected %0d got %0d",
                                         want.bit_value, rsp_ch.bit_value));
            if (rsp_ch.set_count !== want.set_count)
               report_mismatch($sformatf("set_count expected %0d got %0d",
                                         want.set_count, rsp_ch.set_count));
         end
      end
   end

   // Receiver: a requested hold-off first, otherwise random stalls
   int unsigned rsp_stall_left;
   always @(posedge clock) begin
      if (rsp_hold_cycles != 0) begin
         rsp_ch.ready    <= 1'b0;
         rsp_hold_cycles  = rsp_hold_cycles - 1;
      end else if (rsp_stall_left != 0) begin
         rsp_ch.ready   <= 1'b0;
         rsp_stall_left  = rsp_stall_left - 1;
      end else begin
         rsp_ch.ready   <= 1'b1;
         rsp_stall_left  = draw_gap();
      end
   end

   // Watchdog: too long with no item moving on either channel
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         idle_cycles = 0;
      else
         idle_cycles = idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb: timeout, no item moved for %0d cycles", IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      // known values on every input before the first edge
      reset               = 1'b1;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      req_ch.valid        = 1'b0;
      req_ch.opcode       = '0;
      req_ch.target_row   = '0;
      req_ch.source_row   = '0;
      req_ch.bit_position = '0;
      rsp_ch.ready        = 1'b0;
      words_in_use_shadow = bmr_pkg::WORDS_IN_USE_RESET;
      mismatch_count      = 0;
      gaps_enabled        = 1'b1;
      rsp_hold_cycles     = 0;
      rsp_stall_left      = 0;
      idle_cycles         = 0;
      foreach (row_words[r, w])
         row_words[r][w] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The block's clearing pass holds off the first item via ready
      test_directed();
      test_words_in_use_sweep();
      test_result_backpressure();
      test_drain_pause();

      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("tb: success");
      end else begin
         if (pending_results.size() != 0)
            $display("tb: %0d results never arrived", pending_results.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule
